// ===== sv/pbsa_pkg.sv =====
// Shared types, opcodes and arithmetic helpers for the packed byte saturating ALU.
// No dependencies.
`timescale 1ns / 1ps
package pbsa_pkg;

  localparam int unsigned DefaultLanes = 8;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_CPL = 4'd8
  } pbsa_op_e;

  // Lane result handed from a lane to the merge stage.
  typedef struct packed {
    logic [7:0] res_byte;
    logic       wr;
    logic       dzero;
  } pbsa_lane_res_t;

  function automatic logic [7:0] pbsa_clamp(input logic signed [41:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 42'sd255) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // One restoring division step: returns {new partial remainder, quotient bit}.
  function automatic logic [8:0] pbsa_div_step(input logic [7:0] rem, input logic nbit,
                                               input logic [7:0] d);
    logic [8:0] t;
    logic [8:0] r;
    t = {rem, nbit};
    if (t >= {1'b0, d}) begin
      r = {8'(t - {1'b0, d}), 1'b1};
    end else begin
      r = {t[7:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== sv/pbsa_lane.sv =====
// One byte lane: wide saturating arithmetic and a two-stage 8-bit divider.
// Depends on pbsa_pkg.
`timescale 1ns / 1ps
module pbsa_lane
  import pbsa_pkg::*;
(
  input  logic                clk_i,
  input  logic [3:0]          op_i,
  input  logic [7:0]          v_i,
  input  logic signed [31:0]  a_i,
  input  logic                use_i,
  output pbsa_lane_res_t      res_o
);

  logic signed [41:0] vs, as, sum, dif, prd;
  logic signed [40:0] mul;
  logic [31:0]        amag;
  logic [7:0]         misc;
  logic [7:0]         rem_a, q_hi;
  logic [8:0]         st;
  logic               is_div, is_rem, big, apos;

  logic [7:0] misc_d, misc_q, v_d, v_q, d_d, d_q, rem_d, rem_q, qh_d, qh_q;
  logic       div_d, div_q, rmo_d, rmo_q, big_d, big_q, apos_d, apos_q;
  logic       wr_d, wr_q, dz_d, dz_q;

  always_comb begin
    vs   = $signed({34'd0, v_i});
    as   = {{10{a_i[31]}}, a_i};
    sum  = vs + as;
    dif  = vs - as;
    mul  = $signed({1'b0, v_i}) * a_i;
    prd  = {mul[40], mul};
    amag = a_i[31] ? 32'(-a_i) : a_i;
    big  = amag[31:8] != 24'd0;
    apos = !a_i[31] && (a_i != 32'sd0);
    is_div = op_i == OP_DIV;
    is_rem = op_i == OP_REM;
    case (op_i)
      OP_ADD:  misc = pbsa_clamp(sum);
      OP_SUB:  misc = pbsa_clamp(dif);
      OP_MUL:  misc = pbsa_clamp(prd);
      OP_AND:  misc = v_i & a_i[7:0];
      OP_OR:   misc = a_i[31] ? 8'd0 : ((a_i[30:8] != 23'd0) ? 8'hFF : (v_i | a_i[7:0]));
      OP_XOR:  misc = a_i[31] ? 8'd0 : ((a_i[30:8] != 23'd0) ? 8'hFF : (v_i ^ a_i[7:0]));
      OP_CPL:  misc = ~v_i;
      default: misc = v_i;
    endcase
    // First four quotient bits.
    rem_a = 8'd0;
    q_hi  = 8'd0;
    for (int k = 7; k >= 4; k--) begin
      st       = pbsa_div_step(rem_a, v_i[k], amag[7:0]);
      rem_a    = st[8:1];
      q_hi[k]  = st[0];
    end
    misc_d = misc;
    v_d    = v_i;
    d_d    = amag[7:0];
    rem_d  = rem_a;
    qh_d   = q_hi;
    div_d  = is_div;
    rmo_d  = is_rem;
    big_d  = big;
    apos_d = apos;
    wr_d   = use_i;
    dz_d   = use_i && (is_div || is_rem) && (a_i == 32'sd0);
  end

  always_ff @(posedge clk_i) begin
    misc_q <= misc_d;
    v_q    <= v_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
    qh_q   <= qh_d;
    div_q  <= div_d;
    rmo_q  <= rmo_d;
    big_q  <= big_d;
    apos_q <= apos_d;
    wr_q   <= wr_d;
    dz_q   <= dz_d;
  end

  logic [7:0] rem_b, quo;
  logic [8:0] sb;

  always_comb begin
    // Last four quotient bits.
    rem_b = rem_q;
    quo   = qh_q;
    for (int k = 3; k >= 0; k--) begin
      sb     = pbsa_div_step(rem_b, v_q[k], d_q);
      rem_b  = sb[8:1];
      quo[k] = sb[0];
    end
    if (div_q) begin
      res_o.res_byte = (apos_q && !big_q) ? quo : 8'd0;
    end else if (rmo_q) begin
      res_o.res_byte = big_q ? v_q : rem_b;
    end else begin
      res_o.res_byte = misc_q;
    end
    res_o.wr    = wr_q;
    res_o.dzero = dz_q;
  end

endmodule

// ===== sv/pbsa_merge.sv =====
// Merge stage: folds lane results into the packed word, raises the zero-divisor
// error and registers the result. Depends on pbsa_pkg.
`timescale 1ns / 1ps
module pbsa_merge
  import pbsa_pkg::*;
#(
  parameter int unsigned LANES = DefaultLanes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [63:0]    val_i,
  input  logic [3:0]     vlen_i,
  input  logic [3:0]     len_i,
  input  pbsa_lane_res_t lane_i [LANES],
  output logic           valid_o,
  output logic [63:0]    bytes_o,
  output logic [3:0]     len_o,
  output logic           err_o
);

  logic [63:0] bytes_d, bytes_q;
  logic [3:0]  len_d, len_q;
  logic        err_d, err_q, valid_q;

  always_comb begin
    err_d   = 1'b0;
    bytes_d = val_i;
    for (int i = 0; i < LANES; i++) begin
      err_d = err_d | lane_i[i].dzero;
      if (lane_i[i].wr) begin
        bytes_d[8*i +: 8] = lane_i[i].res_byte;
      end
    end
    // Zero divisor: hand the value back untouched.
    if (err_d) begin
      bytes_d = val_i;
      len_d   = vlen_i;
    end else begin
      len_d = len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    len_q   <= len_d;
    err_q   <= err_d;
  end

  assign valid_o = valid_q;
  assign bytes_o = bytes_q;
  assign len_o   = len_q;
  assign err_o   = err_q;

endmodule

// ===== sv/packed_byte_saturating_alu_unit.sv =====
// Top level of the packed byte saturating ALU: operand steering, lanes, merge.
// Depends on pbsa_pkg, pbsa_lane and pbsa_merge.
`timescale 1ns / 1ps
// Usage:
//   Drive the request fields and raise start_i; a request is taken at every
//   clock edge where start_i is high and busy_o is low. busy_o is always low:
//   a new request may enter every cycle.
//   Each request yields one result on result_bytes_o, result_len_o and
//   error_code_o, shown for exactly one cycle with result_valid_o high.
//   The result passes two register stages after the accepting edge: the lane
//   stage with the upper half of the divider, then the lower half of the
//   divider and the merge register.
//   Throughput: one request per cycle; each lane's 8-bit restoring divider is
//   split four steps per stage.
//   The receiver cannot stall; results are dropped if not captured.
//   Reset clears the valid pipeline; requests in flight are lost.
//   Lanes past LANES and past the active length pass through unchanged.
module packed_byte_saturating_alu_unit
  import pbsa_pkg::*;
#(
  parameter int unsigned LANES = DefaultLanes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         op_i,
  input  logic [63:0]        value_bytes_i,
  input  logic [3:0]         value_len_i,
  input  logic               operand_is_vector_i,
  input  logic [63:0]        operand_bytes_i,
  input  logic [3:0]         operand_len_i,
  input  logic signed [31:0] scalar_i,
  output logic               result_valid_o,
  output logic [63:0]        result_bytes_o,
  output logic [3:0]         result_len_o,
  output logic               error_code_o
);

  localparam logic [3:0] LanesW = 4'(LANES);

  logic       accept;
  logic [3:0] vlen, olen, len;
  logic       known_op;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    vlen     = (value_len_i > LanesW) ? LanesW : value_len_i;
    olen     = (operand_len_i > LanesW) ? LanesW : operand_len_i;
    known_op = op_i <= OP_CPL;
    if (op_i != OP_CPL && known_op && operand_is_vector_i && olen > vlen) begin
      len = olen;
    end else begin
      len = vlen;
    end
  end

  pbsa_lane_res_t lane_res [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [7:0]         v;
    logic signed [31:0] a;
    logic               use_l;

    assign v     = (4'(g) < vlen) ? value_bytes_i[8*g +: 8] : 8'd0;
    assign a     = operand_is_vector_i
                   ? ((4'(g) < olen) ? {24'd0, operand_bytes_i[8*g +: 8]} : 32'sd0)
                   : scalar_i;
    assign use_l = known_op && (4'(g) < len);

    pbsa_lane u_lane (
      .clk_i (clk_i),
      .op_i  (op_i),
      .v_i   (v),
      .a_i   (a),
      .use_i (use_l),
      .res_o (lane_res[g])
    );
  end

  // Hold the untouched value and lengths alongside the lane stage.
  logic [63:0] val_q;
  logic [3:0]  vlen_q, len_q;
  logic        valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= value_bytes_i;
    vlen_q <= vlen;
    len_q  <= len;
  end

  pbsa_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q),
    .val_i   (val_q),
    .vlen_i  (vlen_q),
    .len_i   (len_q),
    .lane_i  (lane_res),
    .valid_o (result_valid_o),
    .bytes_o (result_bytes_o),
    .len_o   (result_len_o),
    .err_o   (error_code_o)
  );

endmodule

// ===== verif/pbsa_checker.sv =====
// Watches the request and result ports of the packed byte saturating ALU,
// predicts each result lane by lane and compares it. Depends on pbsa_pkg.
`timescale 1ns / 1ps
module pbsa_checker
  import pbsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [3:0]         op_i,
  input  logic [63:0]        value_bytes_i,
  input  logic [3:0]         value_len_i,
  input  logic               operand_is_vector_i,
  input  logic [63:0]        operand_bytes_i,
  input  logic [3:0]         operand_len_i,
  input  logic signed [31:0] scalar_i,
  input  logic               result_valid_i,
  input  logic [63:0]        result_bytes_i,
  input  logic [3:0]         result_len_i,
  input  logic               error_code_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned LaneCount = 8;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  len;
    logic        err;
  } alu_result_t;

  alu_result_t expected_q[$];
  int          fails = 0;

  function automatic logic [3:0] sat_len(input logic [3:0] n);
    return (n > LaneCount) ? 4'(LaneCount) : n;
  endfunction

  function automatic logic [7:0] sat_arith(input longint x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'hFF;
    return x[7:0];
  endfunction

  // OR and XOR results carry the scalar's sign: a set top bit is negative.
  function automatic logic [7:0] sat_bits(input logic [63:0] x);
    if (x[63]) return 8'd0;
    if (x > 64'd255) return 8'hFF;
    return x[7:0];
  endfunction

  function automatic alu_result_t compute_lanes(
    input logic [3:0] op, input logic [63:0] val, input logic [3:0] vlen_raw,
    input logic is_vec, input logic [63:0] opnd, input logic [3:0] olen_raw,
    input logic signed [31:0] sc);
    alu_result_t r;
    logic [3:0]  vlen;
    logic [3:0]  olen;
    longint      v;
    longint      a;
    logic [7:0]  lane;
    vlen = sat_len(vlen_raw);
    olen = sat_len(olen_raw);
    r.bytes = val;
    r.len = vlen;
    r.err = 1'b0;
    if (op == OP_CPL) begin
      for (int i = 0; i < vlen; i++) r.bytes[8*i +: 8] = ~val[8*i +: 8];
    end else if (op <= OP_XOR) begin
      if (is_vec && olen > vlen) r.len = olen;
      if (op == OP_DIV || op == OP_REM) begin
        for (int i = 0; i < r.len; i++) begin
          a = is_vec ? ((i < olen) ? longint'(opnd[8*i +: 8]) : 0) : longint'(sc);
          if (a == 0) r.err = 1'b1;
        end
      end
      if (r.err) begin
        r.len = vlen;
      end else begin
        for (int i = 0; i < r.len; i++) begin
          v = (i < vlen) ? longint'(val[8*i +: 8]) : 0;
          a = is_vec ? ((i < olen) ? longint'(opnd[8*i +: 8]) : 0) : longint'(sc);
          case (op)
            OP_ADD: lane = sat_arith(v + a);
            OP_SUB: lane = sat_arith(v - a);
            OP_MUL: lane = sat_arith(v * a);
            OP_DIV: lane = sat_arith(v / a);
            OP_REM: lane = sat_arith(v % a);
            OP_AND: lane = sat_bits(64'(v) & 64'(a));
            OP_OR:  lane = sat_bits(64'(v) | 64'(a));
            default: lane = sat_bits(64'(v) ^ 64'(a));
          endcase
          r.bytes[8*i +: 8] = lane;
        end
      end
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (result_valid_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result bytes=%h len=%0d err=%0d", $time,
                 result_bytes_i, result_len_i, error_code_i);
        fails <= fails + 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.bytes !== result_bytes_i || exp_r.len !== result_len_i ||
            exp_r.err !== error_code_i) begin
          $display("%0t: expected bytes=%h len=%0d err=%0d, got bytes=%h len=%0d err=%0d",
                   $time, exp_r.bytes, exp_r.len, exp_r.err,
                   result_bytes_i, result_len_i, error_code_i);
          fails <= fails + 1;
        end
      end
    end
    if (start_i && !busy_i)
      expected_q.push_back(compute_lanes(op_i, value_bytes_i, value_len_i,
                                         operand_is_vector_i, operand_bytes_i,
                                         operand_len_i, scalar_i));
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the packed byte saturating ALU testbench: clock, reset, request
// stimulus and verdict. Depends on pbsa_pkg, the ALU unit and pbsa_checker.
`timescale 1ns / 1ps
module tb_top;
  import pbsa_pkg::*;

  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;
  localparam int RandomRequests = 1800;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [3:0]         op_i = '0;
  logic [63:0]        value_bytes_i = '0;
  logic [3:0]         value_len_i = '0;
  logic               operand_is_vector_i = 1'b0;
  logic [63:0]        operand_bytes_i = '0;
  logic [3:0]         operand_len_i = '0;
  logic signed [31:0] scalar_i = '0;
  logic               result_valid_o;
  logic [63:0]        result_bytes_o;
  logic [3:0]         result_len_o;
  logic               error_code_o;
  int                 fail_count;
  int                 pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packed_byte_saturating_alu_unit u_top (.*);

  pbsa_checker u_checker (
    .clk_i, .start_i, .busy_i(busy_o), .op_i, .value_bytes_i, .value_len_i,
    .operand_is_vector_i, .operand_bytes_i, .operand_len_i, .scalar_i,
    .result_valid_i(result_valid_o), .result_bytes_i(result_bytes_o),
    .result_len_i(result_len_o), .error_code_i(error_code_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Issue one request, hold it until taken, then maybe idle.
  task automatic send_request(input logic [3:0] op, input logic [63:0] val,
                              input logic [3:0] vlen, input logic is_vec,
                              input logic [63:0] opnd, input logic [3:0] olen,
                              input logic [31:0] sc, input bit allow_gap);
    int gap;
    op_i <= op;
    value_bytes_i <= val;
    value_len_i <= vlen;
    operand_is_vector_i <= is_vec;
    operand_bytes_i <= opnd;
    operand_len_i <= olen;
    scalar_i <= sc;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [3:0] pick_len();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
  endfunction

  function automatic logic [31:0] pick_scalar();
    case ($urandom_range(6))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom;
      4: return 32'($signed($urandom_range(600)) - 300);
      default: return 32'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [63:0] pick_bytes();
    logic [63:0] b;
    b = {$urandom, $urandom};
    // Scatter some zero lanes so divide by zero shows up in vector mode.
    if ($urandom_range(3) == 0) b[8*$urandom_range(7) +: 8] = 8'd0;
    if ($urandom_range(4) == 0) b = 64'hFFFF_FFFF_FFFF_FFFF;
    return b;
  endfunction

  initial begin
    logic [3:0] op;
    bit burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every opcode, zero divisor, long lengths, unused ops.
    send_request(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, '0, 4'd0, 32'sh7FFF_FFFF, 0);
    send_request(OP_SUB, 64'h0102_0304_0506_0708, 4'd8, 1'b0, '0, 4'd0, 32'sh8000_0000, 0);
    send_request(OP_MUL, 64'h0010_2030_4050_6070, 4'd8, 1'b1,
                 64'h0203_0405_0607_0809, 4'd6, 32'd0, 1);
    send_request(OP_DIV, 64'hFFFE_FDFC_FBFA_F9F8, 4'd8, 1'b0, '0, 4'd0, -32'sd3, 0);
    send_request(OP_DIV, 64'h1111_2222_3333_4444, 4'd4, 1'b1,
                 64'h0000_0000_0000_0005, 4'd1, 32'd0, 0);
    send_request(OP_REM, 64'hFF80_7F40_3020_1007, 4'd8, 1'b0, '0, 4'd0, 32'd7, 1);
    send_request(OP_REM, 64'hAAAA_AAAA_AAAA_AAAA, 4'd3, 1'b0, '0, 4'd0, 32'd0, 0);
    send_request(OP_DIV, 64'h1234_5678_9ABC_DEF0, 4'd0, 1'b0, '0, 4'd0, 32'd0, 0);
    send_request(OP_REM, 64'h1234_5678_9ABC_DEF0, 4'd2, 1'b1,
                 64'hFFFF_FFFF_FFFF_0101, 4'd15, 32'd0, 0);
    send_request(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, 4'd8, 1'b0, '0, 4'd0, -32'sd1, 0);
    send_request(OP_OR,  64'h0000_0000_0000_0001, 4'd8, 1'b0, '0, 4'd0, -32'sd256, 1);
    send_request(OP_XOR, 64'h5555_5555_5555_5555, 4'd15, 1'b1,
                 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'd0, 0);
    send_request(OP_XOR, 64'h00FF_00FF_00FF_00FF, 4'd5, 1'b0, '0, 4'd0, 32'sh7FFF_FFFF, 0);
    send_request(OP_CPL, 64'h0123_4567_89AB_CDEF, 4'd5, 1'b1,
                 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0, 0);
    send_request(OP_CPL, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b0, '0, 4'd0, 32'd0, 1);
    send_request(OP_ADD, 64'h0000_0000_0000_00FF, 4'd1, 1'b1,
                 64'h0101_0101_0101_0101, 4'd8, 32'd0, 0);
    send_request(OP_SUB, '0, 4'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd0, 0);
    send_request(OpUnusedLo, 64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b0, '0, 4'd0, 32'd0, 0);
    send_request(OpUnusedHi, 64'hDEAD_BEEF_CAFE_F00D, 4'd15, 1'b1,
                 64'h0, 4'd8, 32'd0, 1);

    for (int n = 0; n < RandomRequests; n++) begin
      op = ($urandom_range(15) == 0) ? 4'($urandom_range(OpUnusedLo, OpUnusedHi))
                                     : 4'($urandom_range(OP_CPL));
      // Every so often run a back-to-back burst with no gaps.
      burst = (n % 200) < 40;
      send_request(op, pick_bytes(), pick_len(), 1'($urandom), pick_bytes(), pick_len(),
                   pick_scalar(), !burst);
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
